@@ hw/rtl/hsat_pkg.sv @@
package hsat_pkg;

    localparam int COORD_WIDTH = 36;
    localparam int FRAC_BITS   = 40;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 8;

    localparam int PROD_W = COORD_WIDTH + CFG_W;
    localparam int LO_W   = COORD_WIDTH / 2;
    localparam int HI_W   = COORD_WIDTH - LO_W;
    localparam int TERM_W = PROD_W + 1 - FRAC_BITS;

    localparam int SUM_BASE0 = (COORD_WIDTH > TERM_W) ? COORD_WIDTH : TERM_W;
    localparam int SUM_BASE  = (SUM_BASE0 > CFG_W) ? SUM_BASE0 : CFG_W;
    localparam int SUM_W     = SUM_BASE + 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [CFG_W-1:0]       t_param;
    typedef logic signed [TERM_W-1:0]      t_term;
    typedef logic signed [SUM_W-1:0]       t_sum;

    typedef struct packed {
        logic mul;
        logic rnd;
    } t_prod_en;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 8'd0,
        CFG_SHIFT_X = 8'd1,
        CFG_SHIFT_Y = 8'd2,
        CFG_SHIFT_Z = 8'd3,
        CFG_ROT_X   = 8'd4,
        CFG_ROT_Y   = 8'd5,
        CFG_ROT_Z   = 8'd6,
        CFG_SCALE   = 8'd7
    } t_cfg_idx;

endpackage

@@ hw/rtl/helmert_small_angle_transform.sv @@
// Helmert small-angle transform, one 3-D point in, one transformed point out.
// Input channel: i_valid / o_ready with i_src_x, i_src_y, i_src_z (signed mm).
// Output channel: o_valid / i_ready with o_dst_x, o_dst_y, o_dst_z and
// o_overflow, set when any coordinate was clamped to the coordinate range.
// Config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index selects
// mode, shifts, rotations or scale; unknown indexes are dropped. Write config
// only while no points are in flight.
// Throughput: one point per cycle while i_ready is high. A point passes
// the four register stages (split partial products, product recombine and
// rounding, five-operand sum or shift only in mode 1, saturation into the
// output register), the first of which loads at the input transfer edge.
// Stall: when i_ready is low a valid output register holds; each stage keeps its
// item until the next stage frees up, so bubbles are squeezed out and o_ready
// drops only when every stage is full.
// Reset (synchronous, active low) clears all config registers to zero and
// empties the pipeline.
module helmert_small_angle_transform import hsat_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_coord               i_src_x,
    input  t_coord               i_src_y,
    input  t_coord               i_src_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_coord               o_dst_x,
    output t_coord               o_dst_y,
    output t_coord               o_dst_z,
    output logic                 o_overflow,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam t_sum SAT_MAX = t_sum'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam t_sum SAT_MIN = ~SAT_MAX;

    logic   r_mode;
    t_param r_shift_x, r_shift_y, r_shift_z;
    t_param r_rot_x, r_rot_y, r_rot_z, r_scale;

    logic   r_v1, r_v2, r_v3, r_v4;
    logic   en1, en2, en3, en4;
    t_prod_en prod_en;

    t_coord r_x1, r_y1, r_z1, r_x2, r_y2, r_z2;
    t_term  term_zry, term_yrz, term_xm, term_zrx, term_xrz, term_ym;
    t_term  term_yrx, term_xry, term_zm;
    t_sum   n_sum_x, n_sum_y, n_sum_z;
    t_sum   r_sum_x, r_sum_y, r_sum_z;
    t_coord n_dst_x, n_dst_y, n_dst_z;
    logic   ovf_x, ovf_y, ovf_z;
    t_coord r_dst_x, r_dst_y, r_dst_z;
    logic   r_ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
            r_rot_x   <= '0;
            r_rot_y   <= '0;
            r_rot_z   <= '0;
            r_scale   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:    r_mode    <= i_cfg_data[0];
                CFG_SHIFT_X: r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y: r_shift_y <= i_cfg_data;
                CFG_SHIFT_Z: r_shift_z <= i_cfg_data;
                CFG_ROT_X:   r_rot_x   <= i_cfg_data;
                CFG_ROT_Y:   r_rot_y   <= i_cfg_data;
                CFG_ROT_Z:   r_rot_z   <= i_cfg_data;
                CFG_SCALE:   r_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    assign en4 = !r_v4 || i_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign prod_en = '{mul: en1, rnd: en2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_x1 <= i_src_x;
            r_y1 <= i_src_y;
            r_z1 <= i_src_z;
        end
        if (en2) begin
            r_x2 <= r_x1;
            r_y2 <= r_y1;
            r_z2 <= r_z1;
        end
    end

    hsat_prod u_zry (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_z), .i_b(r_rot_y),
                     .o_term(term_zry));
    hsat_prod u_yrz (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_y), .i_b(r_rot_z),
                     .o_term(term_yrz));
    hsat_prod u_xm  (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_x), .i_b(r_scale),
                     .o_term(term_xm));
    hsat_prod u_zrx (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_z), .i_b(r_rot_x),
                     .o_term(term_zrx));
    hsat_prod u_xrz (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_x), .i_b(r_rot_z),
                     .o_term(term_xrz));
    hsat_prod u_ym  (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_y), .i_b(r_scale),
                     .o_term(term_ym));
    hsat_prod u_yrx (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_y), .i_b(r_rot_x),
                     .o_term(term_yrx));
    hsat_prod u_xry (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_x), .i_b(r_rot_y),
                     .o_term(term_xry));
    hsat_prod u_zm  (.i_clk(i_clk), .i_en(prod_en), .i_a(i_src_z), .i_b(r_scale),
                     .o_term(term_zm));

    always_comb begin
        n_sum_x = SUM_W'(r_x2) + SUM_W'(r_shift_x);
        n_sum_y = SUM_W'(r_y2) + SUM_W'(r_shift_y);
        n_sum_z = SUM_W'(r_z2) + SUM_W'(r_shift_z);
        if (!r_mode) begin
            n_sum_x = n_sum_x - SUM_W'(term_zry) + SUM_W'(term_yrz) + SUM_W'(term_xm);
            n_sum_y = n_sum_y + SUM_W'(term_zrx) - SUM_W'(term_xrz) + SUM_W'(term_ym);
            n_sum_z = n_sum_z - SUM_W'(term_yrx) + SUM_W'(term_xry) + SUM_W'(term_zm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_sum_z <= n_sum_z;
        end
    end

    always_comb begin
        ovf_x = (r_sum_x > SAT_MAX) || (r_sum_x < SAT_MIN);
        ovf_y = (r_sum_y > SAT_MAX) || (r_sum_y < SAT_MIN);
        ovf_z = (r_sum_z > SAT_MAX) || (r_sum_z < SAT_MIN);
        n_dst_x = (r_sum_x > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
                  (r_sum_x < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : r_sum_x[COORD_WIDTH-1:0];
        n_dst_y = (r_sum_y > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
                  (r_sum_y < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : r_sum_y[COORD_WIDTH-1:0];
        n_dst_z = (r_sum_z > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
                  (r_sum_z < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : r_sum_z[COORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_dst_x <= n_dst_x;
            r_dst_y <= n_dst_y;
            r_dst_z <= n_dst_z;
            r_ovf   <= ovf_x || ovf_y || ovf_z;
        end
    end

    assign o_valid    = r_v4;
    assign o_dst_x    = r_dst_x;
    assign o_dst_y    = r_dst_y;
    assign o_dst_z    = r_dst_z;
    assign o_overflow = r_ovf;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_ready)
        else $error("empty first stage not ready");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted point lost at first stage");

    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |->
            (o_dst_x == SAT_MAX[COORD_WIDTH-1:0]) || (o_dst_x == SAT_MIN[COORD_WIDTH-1:0]) ||
            (o_dst_y == SAT_MAX[COORD_WIDTH-1:0]) || (o_dst_y == SAT_MIN[COORD_WIDTH-1:0]) ||
            (o_dst_z == SAT_MAX[COORD_WIDTH-1:0]) || (o_dst_z == SAT_MIN[COORD_WIDTH-1:0]))
        else $error("overflow flagged without a clamped coordinate");

endmodule

@@ hw/rtl/hsat_prod.sv @@
module hsat_prod import hsat_pkg::*; (
    input  logic     i_clk,
    input  t_prod_en i_en,
    input  t_coord   i_a,
    input  t_param   i_b,
    output t_term    o_term
);

    localparam logic signed [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic signed [LO_W:0]             lo_op;
    logic signed [HI_W-1:0]           hi_op;
    logic signed [LO_W+CFG_W:0]       r_lo;
    logic signed [HI_W+CFG_W-1:0]     r_hi;
    logic signed [PROD_W:0]           hi_sh;
    logic signed [PROD_W:0]           lo_ext;
    logic signed [PROD_W:0]           prod;
    logic signed [PROD_W:0]           neg_adj;
    logic signed [PROD_W:0]           rnd;
    t_term                            r_term;

    assign lo_op = $signed({1'b0, i_a[LO_W-1:0]});
    assign hi_op = i_a[COORD_WIDTH-1:LO_W];

    // split multiply: unsigned low half and signed high half
    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_lo <= (LO_W+CFG_W+1)'(lo_op) * (LO_W+CFG_W+1)'(i_b);
            r_hi <= (HI_W+CFG_W)'(hi_op) * (HI_W+CFG_W)'(i_b);
        end
    end

    // recombine, round half away from zero, drop fraction
    always_comb begin
        hi_sh   = {r_hi[HI_W+CFG_W-1], r_hi, {LO_W{1'b0}}};
        lo_ext  = {{HI_W{r_lo[LO_W+CFG_W]}}, r_lo};
        prod    = hi_sh + lo_ext;
        neg_adj = {{PROD_W{1'b0}}, prod[PROD_W]};
        rnd     = prod + HALF - neg_adj;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rnd) begin
            r_term <= rnd[PROD_W:FRAC_BITS];
        end
    end

    assign o_term = r_term;

endmodule
